// ===== design/assert_macros.svh =====
// Assertion helpers for the sequencer. Define ASSERT_OFF to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, checked on every clock edge out of reset
`define ASSERT_IMP(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked on every clock edge out of reset
`define ASSERT_NXT(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMP(lbl, pre, post)
`define ASSERT_NXT(lbl, pre, post)

`endif

`endif

// ===== design/tas_pkg.sv =====
`default_nettype none

package tas_pkg;

    // Field widths
    localparam int SLOT_W     = 3;
    localparam int CHAN_W     = 4;
    localparam int MUX_W      = 5;
    localparam int SAMPLE_W   = 16;
    localparam int STATUS_W   = 2;
    localparam int FUNC_W     = 2;
    localparam int CFG_CHAN_W = 32;
    localparam int CFG_MUX_W  = 40;
    localparam int CFG_DATA_W = 40;
    localparam int CFG_IDX_W  = 2;

    // Default sizes
    localparam int NUM_SLOTS_DEF    = 8;
    localparam int NUM_CHANNELS_DEF = 4;

    // Slot channel code for an unused slot
    localparam logic [CHAN_W-1:0] CH_UNUSED = 4'hF;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SLOT_CHANNELS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MUX_POSITIVE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MUX_NEGATIVE  = 2'd2;

    // Item function codes
    typedef enum logic [FUNC_W-1:0] {
        FUNC_TICK  = 2'd0,
        FUNC_DONE  = 2'd1,
        FUNC_QUERY = 2'd2
    } t_func;

    // Channel status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_NA    = 2'd0,
        ST_OK    = 2'd1,
        ST_ERROR = 2'd2
    } t_status;

    // Sequencer control states
    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } t_state;

    typedef struct packed {
        logic [FUNC_W-1:0]   func;
        logic                start_accepted;
        logic [SLOT_W-1:0]   done_slot;
        logic [SAMPLE_W-1:0] sample;
        logic [CHAN_W-1:0]   query_channel;
    } t_in_item;

    typedef struct packed {
        logic                start_request;
        logic [SLOT_W-1:0]   start_slot;
        logic [MUX_W-1:0]    start_mux_positive;
        logic [MUX_W-1:0]    start_mux_negative;
        logic [SAMPLE_W-1:0] read_value;
        logic                read_ready;
        logic [STATUS_W-1:0] read_status;
    } t_out_item;

    // One channel entry as kept in the channel memory
    typedef struct packed {
        logic [SAMPLE_W-1:0] value;
        logic                ready;
        logic [STATUS_W-1:0] status;
    } t_chan_entry;

    // Slot lookup result carried from accept to execute
    typedef struct packed {
        logic             issue;
        logic             hit;
        logic [SLOT_W-1:0] slot;
        logic [MUX_W-1:0] mux_p;
        logic [MUX_W-1:0] mux_n;
    } t_lookup;

endpackage

`default_nettype wire

// ===== design/tas_ram.sv =====
`default_nettype none

module tas_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write one entry, read one entry with registered data
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== design/timeslot_adc_sequencer.sv =====
`default_nettype none
// Time-triggered ADC sequencer.
// Item channel: an item (tick, conversion done, or channel query) is taken
// at a rising edge where start is high and busy is low. Each item yields
// exactly one result on o_result, marked by o_result_strobe for one cycle.
// The receiver cannot hold results off; results are simply presented.
// Timing: an accepted item, its lookup and the memory read are registered;
// the execute state then modifies the entry and registers the result and
// its strobe. busy is high in the execute state, so the block cannot take a
// new item while one executes. The channel memory sets this: a registered
// read, then modify and write back.
// Configuration channel: i_cfg_valid/o_cfg_ready with i_cfg_index and
// i_cfg_data; ready is always high. Index 0 is the slot channel table
// (4 bits per slot, 15 = unused), 1 and 2 the positive and negative mux
// tables (5 bits per slot). Writes to other indexes are dropped.
// Reset (i_rst_n low, synchronous): busy held high, slot index to 0, all
// slots unused, mux tables cleared, every channel reads as value 0, not
// ready, not available.
// No clearing pass is needed: per-channel valid bits cover the memory.
`include "assert_macros.svh"

module timeslot_adc_sequencer
    import tas_pkg::*;
#(
    parameter int NUM_SLOTS    = NUM_SLOTS_DEF,
    parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire t_in_item              i_item,
    output logic                       o_result_strobe,
    output t_out_item                  o_result,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int SLOT_AW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CH_AW   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    // Control and configuration state
    t_state                r_state, n_state;
    logic [SLOT_AW-1:0]    r_slot_index;
    logic [CFG_CHAN_W-1:0] r_slot_channels;
    logic [CFG_MUX_W-1:0]  r_mux_pos;
    logic [CFG_MUX_W-1:0]  r_mux_neg;
    logic [NUM_CHANNELS-1:0] r_valid;

    // Item held while it executes
    t_in_item              r_item;
    t_lookup               r_look, n_look;
    logic [CH_AW-1:0]      r_addr, n_addr;

    // Result register
    logic                  r_strobe;
    t_out_item             r_result, n_result;

    // Lookup and memory signals
    logic                  accept;
    logic                  exec;
    logic [SLOT_W-1:0]     look_slot;
    logic [CHAN_W-1:0]     slot_ch;
    logic [CHAN_W-1:0]     entry_ch;
    logic                  chan_ok;
    logic                  slot_ok;
    logic                  ram_re;
    logic                  ram_we;
    t_chan_entry           ram_rdata;
    t_chan_entry           entry;
    t_chan_entry           wr_entry;

    assign o_cfg_ready     = 1'b1;
    assign accept          = start && !busy;
    assign o_result_strobe = r_strobe;
    assign o_result        = r_result;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // State outputs: busy doubles as the read/write interlock on the memory
    always_comb begin
        busy = 1'b0;
        exec = 1'b0;
        case (r_state)
            S_IDLE:  busy = 1'b0;
            S_EXEC: begin
                busy = 1'b1;
                exec = 1'b1;
            end
            default: busy = 1'b1;
        endcase
        // Refuse items while reset is held
        if (!i_rst_n) begin
            busy = 1'b1;
        end
    end

    // Look up the slot table for the incoming item
    always_comb begin
        look_slot = (t_func'(i_item.func) == FUNC_TICK) ?
                    SLOT_W'(r_slot_index) : i_item.done_slot;
        slot_ch   = r_slot_channels[look_slot*CHAN_W +: CHAN_W];
        slot_ok   = ((CHAN_W+1)'(i_item.done_slot) < (CHAN_W+1)'(NUM_SLOTS));
        entry_ch  = (t_func'(i_item.func) == FUNC_QUERY) ? i_item.query_channel : slot_ch;
        chan_ok   = ((CHAN_W+1)'(entry_ch) < (CHAN_W+1)'(NUM_CHANNELS));

        n_look       = '0;
        n_look.slot  = look_slot;
        n_look.mux_p = r_mux_pos[look_slot*MUX_W +: MUX_W];
        n_look.mux_n = r_mux_neg[look_slot*MUX_W +: MUX_W];
        case (t_func'(i_item.func))
            FUNC_TICK: begin
                n_look.issue = (slot_ch != CH_UNUSED);
                n_look.hit   = (slot_ch != CH_UNUSED) && chan_ok;
            end
            FUNC_DONE:  n_look.hit = slot_ok && (slot_ch != CH_UNUSED) && chan_ok;
            FUNC_QUERY: n_look.hit = chan_ok;
            default:    n_look.hit = 1'b0;
        endcase
        n_addr = n_look.hit ? entry_ch[CH_AW-1:0] : '0;
        ram_re = accept;
    end

    // Modify the entry read back and form the result
    always_comb begin
        entry    = r_valid[r_addr] ? ram_rdata : '0;
        wr_entry = entry;
        ram_we   = 1'b0;
        n_result = '0;
        case (t_func'(r_item.func))
            FUNC_TICK: begin
                if (r_look.issue) begin
                    n_result.start_request      = 1'b1;
                    n_result.start_slot         = r_look.slot;
                    n_result.start_mux_positive = r_look.mux_p;
                    n_result.start_mux_negative = r_look.mux_n;
                end
                ram_we = exec && r_look.hit;
                if (r_item.start_accepted) begin
                    wr_entry.ready = 1'b0;
                end else begin
                    wr_entry.status = ST_ERROR;
                end
            end
            FUNC_DONE: begin
                ram_we          = exec && r_look.hit;
                wr_entry.value  = r_item.sample;
                wr_entry.ready  = 1'b1;
                wr_entry.status = ST_OK;
            end
            FUNC_QUERY: begin
                if (r_look.hit) begin
                    n_result.read_value  = entry.value;
                    n_result.read_ready  = entry.ready;
                    n_result.read_status = entry.status;
                end
            end
            default: ram_we = 1'b0;
        endcase
    end

    // Hold control state, configuration and valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_slot_index    <= '0;
            r_slot_channels <= '1;
            r_mux_pos       <= '0;
            r_mux_neg       <= '0;
            r_valid         <= '0;
            r_strobe        <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= exec;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_SLOT_CHANNELS: r_slot_channels <= i_cfg_data[CFG_CHAN_W-1:0];
                    CFG_MUX_POSITIVE:  r_mux_pos       <= i_cfg_data[CFG_MUX_W-1:0];
                    CFG_MUX_NEGATIVE:  r_mux_neg       <= i_cfg_data[CFG_MUX_W-1:0];
                    default:           r_mux_neg       <= r_mux_neg;
                endcase
            end
            // Advance the slot index on every accepted tick
            if (accept && (t_func'(i_item.func) == FUNC_TICK)) begin
                if (r_slot_index == SLOT_AW'(NUM_SLOTS - 1)) begin
                    r_slot_index <= '0;
                end else begin
                    r_slot_index <= r_slot_index + SLOT_AW'(1);
                end
            end
            if (ram_we) begin
                r_valid[r_addr] <= 1'b1;
            end
        end
    end

    // Capture the item and its lookup, register the result
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= i_item;
            r_look <= n_look;
            r_addr <= n_addr;
        end
        if (exec) begin
            r_result <= n_result;
        end
    end

    tas_ram #(
        .WIDTH ($bits(t_chan_entry)),
        .DEPTH (NUM_CHANNELS)
    ) u_chan_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_addr),
        .i_wdata (wr_entry),
        .i_re    (ram_re),
        .i_raddr (n_addr),
        .o_rdata (ram_rdata)
    );

    // Checks
    `ASSERT_NXT(a_accept_busy, accept, busy && exec)
    `ASSERT_NXT(a_exec_strobe, exec, o_result_strobe)
    `ASSERT_IMP(a_strobe_after_exec, o_result_strobe, !exec)
    `ASSERT_IMP(a_slot_range, 1'b1, r_slot_index <= SLOT_AW'(NUM_SLOTS - 1))
    `ASSERT_IMP(a_one_function, r_strobe && r_result.start_request, r_result.read_status == ST_NA)

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
`default_nettype none

module testbench;
    import tas_pkg::*;

    // Codes that the package leaves unnamed but the fields can carry
    localparam logic [FUNC_W-1:0]    FUNC_RSVD     = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int PHASES        = 6;
    localparam int PHASE_ITEMS   = 255;
    localparam int SETTLE_CYCLES = 4;

    // Sequencer state mirror: slot tables, channel results, expected queue
    class sequencer_scoreboard;
        bit [CFG_CHAN_W-1:0] chan_table;
        bit [CFG_MUX_W-1:0]  mux_pos;
        bit [CFG_MUX_W-1:0]  mux_neg;
        bit [SLOT_W-1:0]     slot_idx;
        bit [SAMPLE_W-1:0]   chan_value [NUM_CHANNELS_DEF];
        bit                  chan_ready [NUM_CHANNELS_DEF];
        t_status             chan_status [NUM_CHANNELS_DEF];
        t_out_item           expected_results [$];
        int                  mismatches;

        function new();
            chan_table = '1;
            mux_pos    = '0;
            mux_neg    = '0;
            slot_idx   = '0;
            mismatches = 0;
            for (int c = 0; c < NUM_CHANNELS_DEF; c++) begin
                chan_value[c]  = '0;
                chan_ready[c]  = 1'b0;
                chan_status[c] = ST_NA;
            end
        endfunction

        function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_SLOT_CHANNELS: chan_table = data[CFG_CHAN_W-1:0];
                CFG_MUX_POSITIVE:  mux_pos    = data[CFG_MUX_W-1:0];
                CFG_MUX_NEGATIVE:  mux_neg    = data[CFG_MUX_W-1:0];
                default: ;
            endcase
        endfunction

        // Advance the mirror by one item and queue the result it yields
        function void note_item(t_in_item it);
            t_out_item res;
            int        s;
            int        ch;
            res = '0;
            case (it.func)
                FUNC_TICK: begin
                    s  = int'(slot_idx);
                    ch = int'(chan_table[4*s +: 4]);
                    if (ch != CH_UNUSED) begin
                        res.start_request      = 1'b1;
                        res.start_slot         = s[SLOT_W-1:0];
                        res.start_mux_positive = mux_pos[5*s +: 5];
                        res.start_mux_negative = mux_neg[5*s +: 5];
                        if (ch < NUM_CHANNELS_DEF) begin
                            if (it.start_accepted)
                                chan_ready[ch] = 1'b0;
                            else
                                chan_status[ch] = ST_ERROR;
                        end
                    end
                    s = (s + 1 >= NUM_SLOTS_DEF) ? 0 : s + 1;
                    slot_idx = s[SLOT_W-1:0];
                end
                FUNC_DONE: begin
                    s = int'(it.done_slot);
                    if (s < NUM_SLOTS_DEF) begin
                        ch = int'(chan_table[4*s +: 4]);
                        if (ch != CH_UNUSED && ch < NUM_CHANNELS_DEF) begin
                            chan_value[ch]  = it.sample;
                            chan_ready[ch]  = 1'b1;
                            chan_status[ch] = ST_OK;
                        end
                    end
                end
                FUNC_QUERY: begin
                    ch = int'(it.query_channel);
                    if (ch < NUM_CHANNELS_DEF) begin
                        res.read_value  = chan_value[ch];
                        res.read_ready  = chan_ready[ch];
                        res.read_status = chan_status[ch];
                    end
                end
                default: ;
            endcase
            expected_results.push_back(res);
        endfunction

        function void check_result(t_out_item got);
            t_out_item exp;
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: result %h arrived with nothing pending", got);
                return;
            end
            exp = expected_results.pop_front();
            if (got.start_request !== exp.start_request ||
                got.start_slot !== exp.start_slot ||
                got.start_mux_positive !== exp.start_mux_positive ||
                got.start_mux_negative !== exp.start_mux_negative ||
                got.read_value !== exp.read_value ||
                got.read_ready !== exp.read_ready ||
                got.read_status !== exp.read_status) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("ERROR: exp req=%0d slot=%0d mp=%0d mn=%0d val=%h rdy=%0d st=%0d",
                             exp.start_request, exp.start_slot, exp.start_mux_positive,
                             exp.start_mux_negative, exp.read_value, exp.read_ready,
                             exp.read_status);
                    $display("       got req=%0d slot=%0d mp=%0d mn=%0d val=%h rdy=%0d st=%0d",
                             got.start_request, got.start_slot, got.start_mux_positive,
                             got.start_mux_negative, got.read_value, got.read_ready,
                             got.read_status);
                end
            end
        endfunction
    endclass

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  start       = 1'b0;
    logic                  busy;
    t_in_item              i_item      = '0;
    logic                  o_result_strobe;
    t_out_item             o_result;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    sequencer_scoreboard sb = new();
    int burst_left  = 0;
    int cycle_count = 0;

    timeslot_adc_sequencer uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_item          (i_item),
        .o_result_strobe (o_result_strobe),
        .o_result        (o_result),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Note accepted items and check strobed results on the same edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy)
                sb.note_item(i_item);
            if (o_result_strobe)
                sb.check_result(o_result);
        end
    end

    // Hard stop on a hung block
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Random word as wide as a configuration write
    function automatic logic [CFG_DATA_W-1:0] rand_data();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[CFG_DATA_W-1:0];
    endfunction

    function automatic t_in_item item_of(logic [FUNC_W-1:0] func, logic acc,
                                         logic [SLOT_W-1:0] slot,
                                         logic [SAMPLE_W-1:0] sample,
                                         logic [CHAN_W-1:0] qch);
        t_in_item it;
        it.func           = func;
        it.start_accepted = acc;
        it.done_slot      = slot;
        it.sample         = sample;
        it.query_channel  = qch;
        return it;
    endfunction

    // Random item: junk in every field, then a function and its useful content
    function automatic t_in_item random_item();
        t_in_item    it;
        logic [63:0] junk;
        int          r;
        int          prev_slot;
        junk = {$urandom, $urandom};
        it   = junk[$bits(t_in_item)-1:0];
        r    = $urandom_range(0, 99);
        prev_slot = (int'(sb.slot_idx) + NUM_SLOTS_DEF - 1) % NUM_SLOTS_DEF;
        if (r < 40) begin
            it.func           = FUNC_TICK;
            it.start_accepted = ($urandom_range(0, 3) != 0);
        end else if (r < 65) begin
            it.func = FUNC_DONE;
            if ($urandom_range(0, 1) == 1)
                it.done_slot = prev_slot[SLOT_W-1:0];
            case ($urandom_range(0, 7))
                0: it.sample = '0;
                1: it.sample = '1;
                default: ;
            endcase
        end else if (r < 95) begin
            it.func = FUNC_QUERY;
            if ($urandom_range(0, 4) != 0)
                it.query_channel = CHAN_W'($urandom_range(0, NUM_CHANNELS_DEF));
        end else begin
            it.func = FUNC_RSVD;
        end
        return it;
    endfunction

    // Slot channel table for one phase; low modes are the extremes
    function automatic logic [CFG_DATA_W-1:0] phase_channels(int mode);
        logic [CFG_DATA_W-1:0] data;
        int                    code;
        data = rand_data();
        case (mode)
            0: data[CFG_CHAN_W-1:0] = '1;
            1: data[CFG_CHAN_W-1:0] = '0;
            5: ;
            default: begin
                for (int s = 0; s < NUM_SLOTS_DEF; s++) begin
                    if (mode == 2)
                        code = ($urandom_range(0, 4) == 4) ? int'(CH_UNUSED) :
                                                             int'($urandom_range(0, 3));
                    else if (mode == 3)
                        code = $urandom_range(0, NUM_CHANNELS_DEF - 1);
                    else
                        code = $urandom_range(0, 15);
                    data[4*s +: 4] = code[CHAN_W-1:0];
                end
            end
        endcase
        return data;
    endfunction

    // Present one item and hold it until the block takes it
    task automatic send_item(input t_in_item it);
        int gap;
        if (burst_left == 0) begin
            gap        = $urandom_range(1, 8);
            burst_left = $urandom_range(1, 30);
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start  <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (!(start && !busy));
        burst_left--;
    endtask

    // Write all three tables and the spare index back to back
    task automatic program_tables(input logic [CFG_DATA_W-1:0] chans,
                                  input logic [CFG_DATA_W-1:0] pos,
                                  input logic [CFG_DATA_W-1:0] neg);
        logic [CFG_IDX_W-1:0]  idx  [4];
        logic [CFG_DATA_W-1:0] data [4];
        idx[0] = CFG_SLOT_CHANNELS; data[0] = chans;
        idx[1] = CFG_MUX_POSITIVE;  data[1] = pos;
        idx[2] = CFG_MUX_NEGATIVE;  data[2] = neg;
        idx[3] = CFG_IDX_SPARE;     data[3] = rand_data();
        for (int k = 0; k < 4; k++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx[k];
            i_cfg_data  <= data[k];
            do @(posedge i_clk); while (!(i_cfg_valid && o_cfg_ready));
            sb.write_register(idx[k], data[k]);
        end
        i_cfg_valid <= 1'b0;
    endtask

    // Drop start and wait until every expected result is in
    task automatic drain_results();
        start <= 1'b0;
        burst_left = 0;
        do @(posedge i_clk); while (sb.expected_results.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset state: nothing available, unused slots, ignored completion
        send_item(item_of(FUNC_QUERY, 1'b0, 3'd0, 16'h0000, 4'd0));
        send_item(item_of(FUNC_QUERY, 1'b1, 3'd7, 16'hFFFF, 4'd15));
        send_item(item_of(FUNC_TICK, 1'b1, 3'd0, 16'h0000, 4'd0));
        send_item(item_of(FUNC_DONE, 1'b0, 3'd3, 16'hA5A5, 4'd0));
        drain_results();

        // Slots 0..3 on channels 0..3, slot 4 out of range, 5 unused, 6 high, 7 on 3
        program_tables(40'h00_3EF4_3210, 40'hFF_FFFF_FFFF, 40'h12_3456_789A);

        // One full round of ticks with refusals, an invalid channel and a wrap
        send_item(item_of(FUNC_TICK, 1'b0, 3'd0, 16'h0000, 4'd0));
        send_item(item_of(FUNC_TICK, 1'b1, 3'd0, 16'h0000, 4'd0));
        send_item(item_of(FUNC_TICK, 1'b1, 3'd0, 16'h0000, 4'd0));
        send_item(item_of(FUNC_TICK, 1'b0, 3'd0, 16'h0000, 4'd0));
        send_item(item_of(FUNC_TICK, 1'b1, 3'd0, 16'h0000, 4'd0));
        send_item(item_of(FUNC_TICK, 1'b0, 3'd0, 16'h0000, 4'd0));
        send_item(item_of(FUNC_TICK, 1'b0, 3'd0, 16'h0000, 4'd0));
        send_item(item_of(FUNC_TICK, 1'b1, 3'd0, 16'h0000, 4'd0));

        // Completions: valid slots, invalid channel, unused slot, and a reserved function
        send_item(item_of(FUNC_DONE, 1'b0, 3'd0, 16'hFFFF, 4'd0));
        send_item(item_of(FUNC_DONE, 1'b1, 3'd1, 16'h0000, 4'd15));
        send_item(item_of(FUNC_DONE, 1'b0, 3'd4, 16'h1234, 4'd0));
        send_item(item_of(FUNC_DONE, 1'b1, 3'd5, 16'hBEEF, 4'd0));
        send_item(item_of(FUNC_RSVD, 1'b1, 3'd7, 16'hFFFF, 4'd15));

        // Read back every channel, including out of range ones
        send_item(item_of(FUNC_QUERY, 1'b0, 3'd0, 16'h0000, 4'd0));
        send_item(item_of(FUNC_QUERY, 1'b0, 3'd0, 16'h0000, 4'd1));
        send_item(item_of(FUNC_QUERY, 1'b0, 3'd0, 16'h0000, 4'd2));
        send_item(item_of(FUNC_QUERY, 1'b0, 3'd0, 16'h0000, 4'd3));
        send_item(item_of(FUNC_QUERY, 1'b0, 3'd0, 16'h0000, 4'd4));
        send_item(item_of(FUNC_QUERY, 1'b0, 3'd0, 16'h0000, 4'd15));
        drain_results();

        // Random phases, each under a fresh set of tables
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: program_tables(phase_channels(p), 40'hFF_FFFF_FFFF, 40'h00_0000_0000);
                1: program_tables(phase_channels(p), 40'h00_0000_0000, 40'hFF_FFFF_FFFF);
                default: program_tables(phase_channels(p), rand_data(), rand_data());
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_item(random_item());
            drain_results();
        end

        if (sb.mismatches == 0 && sb.expected_results.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
+incdir+design
design/tas_pkg.sv
design/tas_ram.sv
design/timeslot_adc_sequencer.sv
tb/testbench.sv
